FILE: rtl/dpbm_pkg.sv
// ----------------------------------------------------------------------------
// dpbm_pkg
// shared constants and types of the dual-pool buffer manager
// ----------------------------------------------------------------------------
package dpbm_pkg;

   // pool geometry (the large pool must not hold more blocks than the small one)
   localparam int SMALL_COUNT  = 1024;
   localparam int LARGE_COUNT  = 512;
   localparam int COUNT_BITS   = 8;

   localparam int SMALL_IDX_W  = $clog2(SMALL_COUNT);
   localparam int SMALL_LINK_W = $clog2(SMALL_COUNT + 1);
   localparam int LARGE_IDX_W  = $clog2(LARGE_COUNT);
   localparam int LARGE_LINK_W = $clog2(LARGE_COUNT + 1);

   // fixed field widths
   localparam int KIND_W       = 2;
   localparam int SIZE_W       = 16;
   localparam int INDEX_W      = 10;
   localparam int STATUS_W     = 2;

   localparam logic [SIZE_W-1:0]     SMALL_BYTES_RESET = 16'd512;
   localparam logic [COUNT_BITS-1:0] CNT_MAX           = {COUNT_BITS{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_ACQUIRE = 2'd0,
      KIND_RETAIN  = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_SATURATED = 2'd2,
      STATUS_BAD_FREE  = 2'd3
   } status_type;

   // result item, ok in the lowest bit
   typedef struct packed {
      logic                  freed;
      logic [COUNT_BITS-1:0] count_after;
      logic [INDEX_W-1:0]    granted_index;
      logic                  granted_pool;
      status_type            status;
      logic                  ok;
   } rsp_type;

   typedef struct packed {
      logic [SMALL_LINK_W-1:0] link;
      logic [COUNT_BITS-1:0]   cnt;
   } small_word_type;

   typedef struct packed {
      logic [LARGE_LINK_W-1:0] link;
      logic [COUNT_BITS-1:0]   cnt;
   } large_word_type;

endpackage

FILE: rtl/dual_pool_refcounted_buffer_manager.sv
// ----------------------------------------------------------------------------
// dual_pool_refcounted_buffer_manager
// two-pool lifo buffer allocator with per-block reference counts
// ----------------------------------------------------------------------------
// A block manager for a small pool (1024 blocks) and a large pool (512 blocks).
// Each pool keeps a lifo free list as a head register plus one next-link per
// block, and each block has an 8-bit reference count; link and count of a
// block share one word of the pool's synchronous memory. An acquire is served
// from the small pool when expect_size is at most small_block_bytes and that
// pool is not empty, otherwise from the large pool. Retain increments
// (saturating, status 2), release decrements and returns the block to its list
// at zero; a release at zero is refused with status 3. After reset the block
// runs a clearing pass that rebuilds both free chains and zeroes all counts;
// no item is taken during it, csr writes are. For each item the accept cycle
// reads the addressed memory word; the execute state then modifies and writes
// it back and loads the result register once that register is free. The
// result register lets a new item be accepted while the previous result still
// waits; that item finishes once the result has been taken.
// ----------------------------------------------------------------------------
module dual_pool_refcounted_buffer_manager
   import dpbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // expect_size[15:0], pool_select[16], block_index[26:17]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // ok[0], status[2:1], granted_pool[3],
                                    // granted_index[13:4], count_after[21:14], freed[22]
   // configuration: small_block_bytes
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // control state
   state_type               state_ff,       state_in;
   logic [SMALL_IDX_W-1:0]  init_cnt_ff,    init_cnt_in;
   logic [SMALL_LINK_W-1:0] small_head_ff,  small_head_in;
   logic [LARGE_LINK_W-1:0] large_head_ff,  large_head_in;
   logic [SIZE_W-1:0]       small_bytes_ff, small_bytes_in;
   logic                    rsp_valid_ff,   rsp_valid_in;

   // latched operation
   kind_type                op_kind_ff,  op_kind_in;
   logic                    op_pool_ff,  op_pool_in;
   logic [INDEX_W-1:0]      op_addr_ff,  op_addr_in;
   logic                    op_valid_ff, op_valid_in;

   rsp_type                 rsp_ff, rsp_in;

   // memories
   small_word_type          small_mem [SMALL_COUNT];
   large_word_type          large_mem [LARGE_COUNT];
   small_word_type          small_rd_ff;
   large_word_type          large_rd_ff;

   logic                    small_wr_en,  small_rd_en;
   logic [SMALL_IDX_W-1:0]  small_wr_addr, small_rd_addr;
   small_word_type          small_wr_data;
   logic                    large_wr_en,  large_rd_en;
   logic [LARGE_IDX_W-1:0]  large_wr_addr, large_rd_addr;
   large_word_type          large_wr_data;

   // request fields
   kind_type                req_kind;
   logic [SIZE_W-1:0]       req_size;
   logic                    req_pool;
   logic [INDEX_W-1:0]      req_index;

   // accept-side decode
   logic                    acc_pool;
   logic [INDEX_W-1:0]      acc_addr;
   logic                    acc_valid;
   logic                    small_avail, large_avail;

   // execute-side values
   logic [SMALL_LINK_W-1:0] rd_link, wr_link;
   logic [COUNT_BITS-1:0]   rd_cnt,  wr_cnt;
   logic                    wr_en;

   assign req_kind   = kind_type'(req_tuser);
   assign req_size   = req_tdata[15:0];
   assign req_pool   = req_tdata[16];
   assign req_index  = req_tdata[26:17];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   // a head at or beyond the pool size means the list is empty
   assign small_avail = (32'(small_head_ff) < SMALL_COUNT);
   assign large_avail = (32'(large_head_ff) < LARGE_COUNT);

   // choose the memory word an incoming item works on
   always_comb begin
      acc_pool  = 1'b0;
      acc_addr  = req_index;
      acc_valid = 1'b0;
      case (req_kind)
         KIND_ACQUIRE: begin
            if (req_size <= small_bytes_ff && small_avail) begin
               acc_addr  = INDEX_W'(small_head_ff[SMALL_IDX_W-1:0]);
               acc_valid = 1'b1;
            end else begin
               acc_pool  = 1'b1;
               acc_addr  = INDEX_W'(large_head_ff[LARGE_IDX_W-1:0]);
               acc_valid = large_avail;
            end
         end
         KIND_RETAIN, KIND_RELEASE: begin
            acc_pool  = req_pool;
            acc_valid = req_pool ? (32'(req_index) < LARGE_COUNT)
                                 : (32'(req_index) < SMALL_COUNT);
         end
         default: ;
      endcase
   end

   // read data of the pool in use, large link widened
   assign rd_link = op_pool_ff ? SMALL_LINK_W'(large_rd_ff.link) : small_rd_ff.link;
   assign rd_cnt  = op_pool_ff ? large_rd_ff.cnt : small_rd_ff.cnt;

   always_comb begin
      state_in       = state_ff;
      init_cnt_in    = init_cnt_ff;
      small_head_in  = small_head_ff;
      large_head_in  = large_head_ff;
      small_bytes_in = csr_wr_en ? csr_wr_data : small_bytes_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_in         = rsp_ff;
      op_kind_in     = op_kind_ff;
      op_pool_in     = op_pool_ff;
      op_addr_in     = op_addr_ff;
      op_valid_in    = op_valid_ff;

      wr_en          = 1'b0;
      wr_link        = rd_link;
      wr_cnt         = rd_cnt;

      small_wr_en    = 1'b0;
      small_wr_addr  = op_addr_ff[SMALL_IDX_W-1:0];
      small_wr_data  = '{link: wr_link, cnt: wr_cnt};
      large_wr_en    = 1'b0;
      large_wr_addr  = op_addr_ff[LARGE_IDX_W-1:0];
      large_wr_data  = '{link: wr_link[LARGE_LINK_W-1:0], cnt: wr_cnt};
      small_rd_en    = 1'b0;
      small_rd_addr  = acc_addr[SMALL_IDX_W-1:0];
      large_rd_en    = 1'b0;
      large_rd_addr  = acc_addr[LARGE_IDX_W-1:0];

      unique case (state_ff)
         ST_INIT: begin
            // rebuild both chains: entry i links to i+1, count zero
            small_wr_en   = 1'b1;
            small_wr_addr = init_cnt_ff;
            small_wr_data = '{link: SMALL_LINK_W'(init_cnt_ff) + SMALL_LINK_W'(1),
                              cnt: '0};
            large_wr_en   = (32'(init_cnt_ff) < LARGE_COUNT);
            large_wr_addr = init_cnt_ff[LARGE_IDX_W-1:0];
            large_wr_data = '{link: LARGE_LINK_W'(init_cnt_ff) + LARGE_LINK_W'(1),
                              cnt: '0};
            init_cnt_in   = init_cnt_ff + SMALL_IDX_W'(1);
            if (init_cnt_ff == SMALL_IDX_W'(SMALL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_kind_in  = req_kind;
               op_pool_in  = acc_pool;
               op_addr_in  = acc_addr;
               op_valid_in = acc_valid && (req_kind == KIND_ACQUIRE ||
                                           req_kind == KIND_RETAIN ||
                                           req_kind == KIND_RELEASE);
               small_rd_en = acc_valid && !acc_pool;
               large_rd_en = acc_valid && acc_pool;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // finish only once the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in = '0;
               case (op_kind_ff)
                  KIND_ACQUIRE: begin
                     if (op_valid_ff) begin
                        wr_en                = 1'b1;
                        wr_cnt               = COUNT_BITS'(1);
                        rsp_in.ok            = 1'b1;
                        rsp_in.granted_pool  = op_pool_ff;
                        rsp_in.granted_index = op_addr_ff;
                        rsp_in.count_after   = COUNT_BITS'(1);
                        // pop: head follows the link of the granted block
                        if (op_pool_ff) begin
                           large_head_in = rd_link[LARGE_LINK_W-1:0];
                        end else begin
                           small_head_in = rd_link;
                        end
                     end else begin
                        rsp_in.status = STATUS_EMPTY;
                     end
                  end
                  KIND_RETAIN: begin
                     if (!op_valid_ff) begin
                        rsp_in.status = STATUS_BAD_FREE;
                     end else if (rd_cnt == CNT_MAX) begin
                        rsp_in.status      = STATUS_SATURATED;
                        rsp_in.count_after = rd_cnt;
                     end else begin
                        wr_en              = 1'b1;
                        wr_cnt             = rd_cnt + COUNT_BITS'(1);
                        rsp_in.ok          = 1'b1;
                        rsp_in.count_after = rd_cnt + COUNT_BITS'(1);
                     end
                  end
                  KIND_RELEASE: begin
                     if (!op_valid_ff || rd_cnt == '0) begin
                        rsp_in.status = STATUS_BAD_FREE;
                     end else begin
                        wr_en              = 1'b1;
                        wr_cnt             = rd_cnt - COUNT_BITS'(1);
                        rsp_in.ok          = 1'b1;
                        rsp_in.count_after = rd_cnt - COUNT_BITS'(1);
                        // last reference gone: push onto the free list
                        if (rd_cnt == COUNT_BITS'(1)) begin
                           rsp_in.freed = 1'b1;
                           if (op_pool_ff) begin
                              wr_link       = SMALL_LINK_W'(large_head_ff);
                              large_head_in = LARGE_LINK_W'(op_addr_ff);
                           end else begin
                              wr_link       = small_head_ff;
                              small_head_in = SMALL_LINK_W'(op_addr_ff);
                           end
                        end
                     end
                  end
                  default: ;
               endcase
               small_wr_en   = wr_en && !op_pool_ff;
               small_wr_data = '{link: wr_link, cnt: wr_cnt};
               large_wr_en   = wr_en && op_pool_ff;
               large_wr_data = '{link: wr_link[LARGE_LINK_W-1:0], cnt: wr_cnt};
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         init_cnt_ff    <= '0;
         small_head_ff  <= '0;
         large_head_ff  <= '0;
         small_bytes_ff <= SMALL_BYTES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         init_cnt_ff    <= init_cnt_in;
         small_head_ff  <= small_head_in;
         large_head_ff  <= large_head_in;
         small_bytes_ff <= small_bytes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_kind_ff  <= op_kind_in;
      op_pool_ff  <= op_pool_in;
      op_addr_ff  <= op_addr_in;
      op_valid_ff <= op_valid_in;
      rsp_ff      <= rsp_in;
   end

   // small pool memory: link and count per block
   always_ff @(posedge clock) begin
      if (small_wr_en) begin
         small_mem[small_wr_addr] <= small_wr_data;
      end
      if (small_rd_en) begin
         small_rd_ff <= small_mem[small_rd_addr];
      end
   end

   // large pool memory
   always_ff @(posedge clock) begin
      if (large_wr_en) begin
         large_mem[large_wr_addr] <= large_wr_data;
      end
      if (large_rd_en) begin
         large_rd_ff <= large_mem[large_rd_addr];
      end
   end

`ifndef SYNTHESIS
   a_init_quiet : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT |-> !req_tready && !rsp_tvalid)
      else $error("item traffic during clearing pass");

   a_ok_status : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.ok |-> rsp_ff.status == STATUS_OK)
      else $error("successful result with error status");

   a_freed_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.freed |-> rsp_ff.ok && rsp_ff.count_after == '0)
      else $error("block freed with nonzero count");

   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted before write-back");

   a_result_from_exec : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_EXEC)
      else $error("result raised outside execute");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the dual-pool reference-counted buffer manager
// ----------------------------------------------------------------------------
// Requests are queued by a stimulus process and driven by a clocked driver.
// At each accepted request a local model of both free lists and all reference
// counts works out the expected result, and a clocked monitor compares every
// result field by field. The run walks through directed corner cases, a
// saturating retain burst, a pass that drains the large pool, and mixed
// traffic at several small-block thresholds.
// ----------------------------------------------------------------------------
module testbench;
   import dpbm_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNDEFINED = 2'd3;   // not a legal operation
   localparam logic              POOL_SMALL     = 1'b0;
   localparam logic              POOL_LARGE     = 1'b1;
   localparam int unsigned       WATCHDOG_LIMIT = 5000;   // covers the clearing pass

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [SIZE_W-1:0]  expect_size;
      logic               pool_select;
      logic [INDEX_W-1:0] block_index;
   } buf_request_type;

   typedef struct {
      logic               pool;
      logic [INDEX_W-1:0] index;
   } held_block_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // expect_size[15:0], pool_select[16], block_index[26:17]
   logic [1:0]  req_tuser   = '0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;          // ok[0], status[2:1], granted_pool[3],
                                    // granted_index[13:4], count_after[21:14], freed[22]
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // local copy of the allocator state
   logic [SIZE_W-1:0]       small_bytes = SMALL_BYTES_RESET;
   logic [SMALL_LINK_W-1:0] small_links  [SMALL_COUNT];
   logic [SMALL_LINK_W-1:0] small_head;
   logic [COUNT_BITS-1:0]   small_counts [SMALL_COUNT];
   logic [LARGE_LINK_W-1:0] large_links  [LARGE_COUNT];
   logic [LARGE_LINK_W-1:0] large_head;
   logic [COUNT_BITS-1:0]   large_counts [LARGE_COUNT];

   buf_request_type pending_requests [$];
   rsp_type         expected_results [$];
   held_block_type  held_blocks      [$];   // blocks handed out and not yet freed
   buf_request_type req_cur;

   int unsigned req_gap, rsp_gap;
   bit          req_steady, rsp_steady;
   int unsigned idle_cycles;
   int unsigned mismatch_count;
   int unsigned n_requests, n_small_grants, n_large_grants, n_empty;
   int unsigned n_saturated, n_refused, n_freed;

   dual_pool_refcounted_buffer_manager u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // idle length before the next item; now and then flips into a run with no idling
   function automatic int unsigned draw_wait(inout bit steady);
      if ($urandom_range(19) == 0) steady = !steady;
      return steady ? 0 : $urandom_range(6);
   endfunction

   // applies one accepted request to the local state and returns its result
   function automatic rsp_type expected_outcome(input buf_request_type rq);
      rsp_type               r;
      logic [COUNT_BITS-1:0] cnt;
      int unsigned           blk;
      int unsigned           limit;
      r = '0;
      n_requests++;
      if (rq.kind == KIND_ACQUIRE) begin
         if (rq.expect_size <= small_bytes && 32'(small_head) < SMALL_COUNT) begin
            blk = 32'(small_head);
            small_head = small_links[blk];
            small_counts[blk] = COUNT_BITS'(1);
            r.ok = 1'b1;
            r.granted_pool = POOL_SMALL;
            r.granted_index = INDEX_W'(blk);
            r.count_after = COUNT_BITS'(1);
            held_blocks.push_back('{POOL_SMALL, INDEX_W'(blk)});
            n_small_grants++;
         end else if (32'(large_head) < LARGE_COUNT) begin
            // too big for the small pool, or the small pool has run dry
            blk = 32'(large_head);
            large_head = large_links[blk];
            large_counts[blk] = COUNT_BITS'(1);
            r.ok = 1'b1;
            r.granted_pool = POOL_LARGE;
            r.granted_index = INDEX_W'(blk);
            r.count_after = COUNT_BITS'(1);
            held_blocks.push_back('{POOL_LARGE, INDEX_W'(blk)});
            n_large_grants++;
         end else begin
            r.status = STATUS_EMPTY;
            n_empty++;
         end
      end else if (rq.kind == KIND_RETAIN || rq.kind == KIND_RELEASE) begin
         limit = rq.pool_select ? LARGE_COUNT : SMALL_COUNT;
         blk = 32'(rq.block_index);
         if (blk >= limit) begin
            // index beyond the pool: refused, nothing touched
            r.status = STATUS_BAD_FREE;
            n_refused++;
         end else begin
            cnt = rq.pool_select ? large_counts[blk] : small_counts[blk];
            if (rq.kind == KIND_RETAIN) begin
               if (cnt == CNT_MAX) begin
                  r.status = STATUS_SATURATED;
                  r.count_after = cnt;
                  n_saturated++;
               end else begin
                  // a free block may be retained too; it stays on its list
                  cnt++;
                  r.ok = 1'b1;
                  r.count_after = cnt;
               end
            end else if (cnt == '0) begin
               r.status = STATUS_BAD_FREE;
               n_refused++;
            end else begin
               cnt--;
               r.ok = 1'b1;
               r.count_after = cnt;
               if (cnt == '0) begin
                  // last reference gone: push onto the head of its list
                  r.freed = 1'b1;
                  n_freed++;
                  if (rq.pool_select) begin
                     large_links[blk] = large_head;
                     large_head = LARGE_LINK_W'(blk);
                  end else begin
                     small_links[blk] = small_head;
                     small_head = SMALL_LINK_W'(blk);
                  end
                  for (int i = 0; i < held_blocks.size(); i++) begin
                     if (held_blocks[i].pool == rq.pool_select &&
                         held_blocks[i].index == rq.block_index) begin
                        held_blocks.delete(i);
                        break;
                     end
                  end
               end
            end
            if (rq.pool_select) large_counts[blk] = cnt;
            else small_counts[blk] = cnt;
         end
      end
      // undefined kind leaves everything alone and answers with zeros
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // request driver: holds an item until taken, then idles a random while
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(expected_outcome(req_cur));
            req_gap = draw_wait(req_steady);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_cur = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {5'b0, req_cur.block_index, req_cur.pool_select,
                             req_cur.expect_size};
               req_tuser <= req_cur.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure after each item
   always @(posedge clock) begin : rsp_monitor
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[22:0]);
            if (expected_results.size() == 0) begin
               $error("result item with nothing outstanding: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("ok", 32'(want.ok), 32'(got.ok));
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("granted_pool", 32'(want.granted_pool), 32'(got.granted_pool));
               check_field("granted_index", 32'(want.granted_index),
                           32'(got.granted_index));
               check_field("count_after", 32'(want.count_after), 32'(got.count_after));
               check_field("freed", 32'(want.freed), 32'(got.freed));
               check_field("tdata padding", 0, 32'(rsp_tdata[23]));
            end
            rsp_gap = draw_wait(rsp_steady);
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ends the run when nothing moves on either channel for too long
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic feed_op(input logic [KIND_W-1:0] kind, input logic [SIZE_W-1:0] size,
                          input logic pool, input logic [INDEX_W-1:0] index);
      buf_request_type rq;
      rq.kind = kind;
      rq.expect_size = size;
      rq.pool_select = pool;
      rq.block_index = index;
      // keep the queue short so targets are picked from nearly current state
      while (pending_requests.size() >= 2) @(negedge clock);
      pending_requests.push_back(rq);
   endtask

   // acq_pct: share of acquires; noise_pct: share of retain/release aimed at
   // random blocks rather than held ones; fit_pct: share of acquires sized
   // around the small-block threshold
   task automatic random_op(input int unsigned acq_pct, input int unsigned noise_pct,
                            input int unsigned fit_pct);
      int unsigned       roll;
      logic [SIZE_W-1:0] size;
      logic [KIND_W-1:0] op;
      held_block_type    tgt;
      roll = $urandom_range(99);
      if (roll < acq_pct) begin
         if ($urandom_range(99) < fit_pct) begin
            if ($urandom_range(1)) size = SIZE_W'($urandom_range(small_bytes));
            else size = SIZE_W'(32'(small_bytes) + $urandom_range(2) - 1);
         end else begin
            size = SIZE_W'($urandom);
         end
         feed_op(KIND_ACQUIRE, size, 1'($urandom), INDEX_W'($urandom));
      end else if (roll < acq_pct + 3) begin
         feed_op(KIND_UNDEFINED, SIZE_W'($urandom), 1'($urandom), INDEX_W'($urandom));
      end else begin
         op = $urandom_range(1) ? KIND_RELEASE : KIND_RETAIN;
         if (held_blocks.size() > 0 && $urandom_range(99) >= noise_pct) begin
            tgt = held_blocks[$urandom_range(held_blocks.size() - 1)];
            feed_op(op, SIZE_W'($urandom), tgt.pool, tgt.index);
         end else begin
            feed_op(op, SIZE_W'($urandom), 1'($urandom), INDEX_W'($urandom));
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_small_bytes(input logic [SIZE_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      small_bytes = value;
   endtask

   initial begin : stimulus
      held_block_type    tgt;
      logic [SIZE_W-1:0] mid_bytes;
      // both pools start as ordered chains with every count at zero
      for (int i = 0; i < SMALL_COUNT; i++) begin
         small_links[i] = SMALL_LINK_W'(i + 1);
         small_counts[i] = '0;
      end
      for (int i = 0; i < LARGE_COUNT; i++) begin
         large_links[i] = LARGE_LINK_W'(i + 1);
         large_counts[i] = '0;
      end
      small_head = '0;
      large_head = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed corners at the reset threshold of 512 bytes
      feed_op(KIND_ACQUIRE, 16'd512, POOL_SMALL, '0);       // exactly at threshold
      feed_op(KIND_ACQUIRE, 16'd513, POOL_LARGE, '1);       // one over: large pool
      feed_op(KIND_ACQUIRE, 16'd0, POOL_SMALL, '0);
      feed_op(KIND_ACQUIRE, 16'hFFFF, POOL_SMALL, '0);
      feed_op(KIND_RETAIN, 16'd0, POOL_SMALL, 10'd0);
      feed_op(KIND_RELEASE, 16'd0, POOL_SMALL, 10'd0);
      feed_op(KIND_RELEASE, 16'd0, POOL_SMALL, 10'd0);      // drops to zero, freed
      feed_op(KIND_RELEASE, 16'd0, POOL_SMALL, 10'd0);      // already free: refused
      feed_op(KIND_RETAIN, 16'd0, POOL_SMALL, 10'd5);       // retain of a free block
      feed_op(KIND_ACQUIRE, 16'd1, POOL_SMALL, '0);         // lifo: freed block comes back
      feed_op(KIND_ACQUIRE, 16'd1, POOL_SMALL, '0);
      feed_op(KIND_RETAIN, 16'd0, POOL_LARGE, 10'd511);     // last valid large block
      feed_op(KIND_RETAIN, 16'd0, POOL_LARGE, 10'd512);     // out of range
      feed_op(KIND_RELEASE, 16'hFFFF, POOL_LARGE, 10'd1023);
      feed_op(KIND_RELEASE, 16'd0, POOL_SMALL, 10'd1023);   // count zero
      feed_op(KIND_UNDEFINED, 16'hFFFF, POOL_LARGE, 10'd1023);
      feed_op(KIND_RELEASE, 16'd0, POOL_LARGE, 10'd0);
      feed_op(KIND_RELEASE, 16'd0, POOL_LARGE, 10'd1);
      feed_op(KIND_RETAIN, 16'd0, POOL_SMALL, 10'd1023);
      feed_op(KIND_RELEASE, 16'd0, POOL_SMALL, 10'd1023);
      feed_op(KIND_ACQUIRE, 16'd200, POOL_SMALL, '0);       // picks up the top block
      feed_op(KIND_RELEASE, 16'd0, POOL_LARGE, 10'd511);
      feed_op(KIND_ACQUIRE, 16'd4096, POOL_SMALL, '0);
      wait_idle();

      // widest threshold: drive one block's count into saturation
      write_small_bytes(16'hFFFF);
      feed_op(KIND_ACQUIRE, SIZE_W'($urandom), POOL_SMALL, '0);
      wait_idle();
      tgt = held_blocks[$];
      repeat (32'(CNT_MAX) + 1) feed_op(KIND_RETAIN, SIZE_W'($urandom), tgt.pool, tgt.index);
      repeat (2) feed_op(KIND_RELEASE, SIZE_W'($urandom), tgt.pool, tgt.index);
      repeat (120) random_op(35, 10, 50);
      wait_idle();

      // narrowest threshold: almost everything lands in the large pool until it runs dry
      write_small_bytes(16'd1);
      repeat (620) random_op(94, 0, 6);
      wait_idle();

      // some threshold in between, release-heavy traffic to hand blocks back
      mid_bytes = SIZE_W'($urandom_range(65534, 2));
      write_small_bytes(mid_bytes);
      repeat (260) random_op(25, 10, 40);
      wait_idle();

      repeat (8) @(posedge clock);
      $display("%0d requests across thresholds 512, 65535, 1 and %0d; %0d blocks freed",
               n_requests, mid_bytes, n_freed);
      $display("grants small %0d large %0d; refusals empty %0d saturated %0d bad %0d",
               n_small_grants, n_large_grants, n_empty, n_saturated, n_refused);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
